### hdl/edh_pkg.sv
// ----------------------------------------------------------------------------
// edh_pkg
// Shared types and constants of the distance histogram unit.
// ----------------------------------------------------------------------------
package edh_pkg;

   localparam int CMD_BITS   = 2;
   localparam int COORD_BITS = 8;
   localparam int INDEX_BITS = 12;
   localparam int DIST_BITS  = 12;
   localparam int COUNT_BITS = 20;
   localparam int DIM_BITS   = 8;

   localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

   localparam logic RESULT_DISTANCE = 1'b0;
   localparam logic RESULT_COUNT    = 1'b1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      JOB_DIST,
      JOB_READ,
      JOB_CLEAR
   } job_kind_type;

   typedef struct packed {
      job_kind_type          kind;
      logic [INDEX_BITS-1:0] bin_index;
   } job_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQRT,
      ST_SAT,
      ST_HIST_RD,
      ST_HIST_WR,
      ST_READ_RD,
      ST_READ_DONE
   } back_state_type;

endpackage

### hdl/edh_ram.sv
// ----------------------------------------------------------------------------
// edh_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module edh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/edh_front.sv
// ----------------------------------------------------------------------------
// edh_front
// Takes transactions, keeps the reference vector and sums squared differences.
// ----------------------------------------------------------------------------
module edh_front import edh_pkg::*; #(
   parameter int MAX_DIM = 128,
   localparam int ACC_BITS = 2 * COORD_BITS + $clog2(MAX_DIM)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_BITS-1:0]       req_command,
   input  logic [COORD_BITS-1:0]     req_coordinate,
   input  logic [INDEX_BITS-1:0]     req_bin_index,
   input  logic                      csr_write_enable,
   input  logic [DIM_BITS-1:0]       csr_write_data,
   input  logic [QUEUE_CNT_BITS-1:0] queue_count,
   input  logic                      back_clearing,
   output logic                      push_valid,
   output job_type                   push_job,
   output logic [ACC_BITS-1:0]       push_acc
);

   localparam int PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic [DIM_BITS-1:0]     dim_ff, dim_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic                    loaded_ff, loaded_in;
   logic                    s1_valid_ff, s1_valid_in;
   job_kind_type            s1_kind_ff, s1_kind_in;
   logic                    s1_last_ff;
   logic [COORD_BITS-1:0]   s1_coord_ff;
   logic [INDEX_BITS-1:0]   s1_index_ff;
   logic                    s2_valid_ff;
   job_kind_type            s2_kind_ff;
   logic                    s2_last_ff;
   logic [2*COORD_BITS-1:0] s2_square_ff;
   logic [INDEX_BITS-1:0]   s2_index_ff;
   logic [ACC_BITS-1:0]     acc_ff, acc_in, acc_sum;

   logic                    accept;
   logic                    last_pos;
   int                      eff_dim;
   logic                    ref_we;
   logic [COORD_BITS-1:0]   ref_data;
   logic [COORD_BITS-1:0]   diff;
   logic [2*COORD_BITS-1:0] square;

   // anything in the pipe holds a queue slot, so a push never finds it full
   assign req_stall = back_clearing ||
      (int'(queue_count) + int'(s1_valid_ff) + int'(s2_valid_ff) >= QUEUE_DEPTH);
   assign accept = req_valid && !req_stall;

   always_comb begin
      eff_dim = int'(dim_ff);
      if (eff_dim == 0) begin
         eff_dim = 1;
      end
      if (eff_dim > MAX_DIM) begin
         eff_dim = MAX_DIM;
      end
      last_pos = (int'(pos_ff) + 1 >= eff_dim);
   end

   assign ref_we = accept && (req_command == CMD_SAMPLE) && !loaded_ff;

   edh_ram #(
      .WIDTH (COORD_BITS),
      .DEPTH (MAX_DIM)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (pos_ff),
      .wr_data (req_coordinate),
      .rd_addr (pos_ff),
      .rd_data (ref_data)
   );

   always_comb begin
      dim_in      = csr_write_enable ? csr_write_data : dim_ff;
      pos_in      = pos_ff;
      loaded_in   = loaded_ff;
      s1_valid_in = 1'b0;
      s1_kind_in  = JOB_DIST;
      if (accept) begin
         case (req_command)
            CMD_SAMPLE: begin
               pos_in = last_pos ? '0 : pos_ff + 1'b1;
               if (!loaded_ff) begin
                  if (last_pos) begin
                     loaded_in = 1'b1;
                  end
               end else begin
                  s1_valid_in = 1'b1;
               end
            end
            CMD_READ: begin
               s1_valid_in = 1'b1;
               s1_kind_in  = JOB_READ;
            end
            CMD_CLEAR: begin
               s1_valid_in = 1'b1;
               s1_kind_in  = JOB_CLEAR;
               pos_in      = '0;
               loaded_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // stage 1: reference entry arrives, square the difference
   always_comb begin
      diff   = (s1_coord_ff >= ref_data) ? s1_coord_ff - ref_data : ref_data - s1_coord_ff;
      square = (2*COORD_BITS)'(diff) * (2*COORD_BITS)'(diff);
   end

   // stage 2: accumulate, hand finished vectors and commands to the queue
   always_comb begin
      acc_sum = acc_ff + ACC_BITS'(s2_square_ff);
      acc_in  = acc_ff;
      if (s2_valid_ff) begin
         case (s2_kind_ff)
            JOB_DIST:  acc_in = s2_last_ff ? '0 : acc_sum;
            JOB_CLEAR: acc_in = '0;
            default:   acc_in = acc_ff;
         endcase
      end
      push_valid         = s2_valid_ff && ((s2_kind_ff != JOB_DIST) || s2_last_ff);
      push_job.kind      = s2_kind_ff;
      push_job.bin_index = s2_index_ff;
      push_acc           = acc_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff      <= DIM_BITS'(1);
         pos_ff      <= '0;
         loaded_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         dim_ff      <= dim_in;
         pos_ff      <= pos_in;
         loaded_ff   <= loaded_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= s1_kind_in;
         s1_last_ff  <= last_pos;
         s1_coord_ff <= req_coordinate;
         s1_index_ff <= req_bin_index;
      end
      s2_kind_ff   <= s1_kind_ff;
      s2_last_ff   <= s1_last_ff;
      s2_square_ff <= square;
      s2_index_ff  <= s1_index_ff;
   end

endmodule

### hdl/edh_queue.sv
// ----------------------------------------------------------------------------
// edh_queue
// Short FIFO of jobs between the front and the back.
// ----------------------------------------------------------------------------
module edh_queue import edh_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          head_data,
   output logic                      empty,
   output logic [QUEUE_CNT_BITS-1:0] count
);

   logic [WIDTH-1:0]          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = entry_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);
   assign count     = count_ff;

endmodule

### hdl/edh_back.sv
// ----------------------------------------------------------------------------
// edh_back
// Square root, histogram update, bin reads and histogram clearing.
// ----------------------------------------------------------------------------
module edh_back import edh_pkg::*; #(
   parameter int MAX_DIM   = 128,
   parameter int HIST_BINS = 4096,
   localparam int ACC_BITS = 2 * COORD_BITS + $clog2(MAX_DIM)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  job_type               head_job,
   input  logic [ACC_BITS-1:0]   head_acc,
   output logic                  pop,
   output logic                  clearing,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_result_kind,
   output logic [DIST_BITS-1:0]  rsp_distance,
   output logic [COUNT_BITS-1:0] rsp_bin_count
);

   localparam int HB        = $clog2(HIST_BINS);
   localparam int ROOT_BITS = (ACC_BITS + 1) / 2;
   localparam int IW        = $clog2(ROOT_BITS + 1);
   localparam logic [ACC_BITS-1:0] BIT_TOP = ACC_BITS'(1) << (2 * (ROOT_BITS - 1));

   back_state_type          state_ff, state_in;
   logic [ACC_BITS-1:0]     rem_ff, rem_in;
   logic [ACC_BITS-1:0]     root_ff, root_in;
   logic [ACC_BITS-1:0]     bit_ff, bit_in;
   logic [IW-1:0]           iter_ff, iter_in;
   logic [HB-1:0]           bin_ff, bin_in;
   logic                    oor_ff, oor_in;
   logic [HB-1:0]           clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff;
   logic [DIST_BITS-1:0]    rsp_dist_ff;
   logic [COUNT_BITS-1:0]   rsp_count_ff;

   logic                    out_free;
   logic                    load_out;
   logic                    out_kind;
   logic [DIST_BITS-1:0]    out_dist;
   logic [COUNT_BITS-1:0]   out_count;
   logic                    ram_we;
   logic [HB-1:0]           ram_wa;
   logic [COUNT_BITS-1:0]   ram_wd;
   logic [COUNT_BITS-1:0]   ram_rd;
   logic [ACC_BITS:0]       trial;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign clearing = (state_ff == ST_CLEAR);

   edh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (HIST_BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (bin_ff),
      .rd_data (ram_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == HB'(HIST_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               case (head_job.kind)
                  JOB_DIST:  state_in = ST_SQRT;
                  JOB_READ:  state_in = ST_READ_RD;
                  JOB_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQRT: begin
            if (iter_ff == IW'(ROOT_BITS - 1)) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT:     state_in = ST_HIST_RD;
         ST_HIST_RD: state_in = ST_HIST_WR;
         ST_HIST_WR: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ_RD: state_in = ST_READ_DONE;
         ST_READ_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop       = 1'b0;
      ram_we    = 1'b0;
      ram_wa    = bin_ff;
      ram_wd    = '0;
      load_out  = 1'b0;
      out_kind  = RESULT_DISTANCE;
      out_dist  = '0;
      out_count = '0;
      rem_in    = rem_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      iter_in   = iter_ff;
      bin_in    = bin_ff;
      oor_in    = oor_ff;
      clr_in    = clr_ff;
      trial     = {1'b0, root_ff} + {1'b0, bit_ff};
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               rem_in  = head_acc;
               root_in = '0;
               bit_in  = BIT_TOP;
               iter_in = '0;
               bin_in  = HB'(head_job.bin_index);
               oor_in  = (int'(head_job.bin_index) >= HIST_BINS);
               clr_in  = '0;
            end
         end
         ST_SQRT: begin
            // one result bit per cycle
            if ({1'b0, rem_ff} >= trial) begin
               rem_in  = rem_ff - trial[ACC_BITS-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff + 1'b1;
         end
         ST_SAT: begin
            bin_in = (root_ff > ACC_BITS'(HIST_BINS - 1)) ? HB'(HIST_BINS - 1) : HB'(root_ff);
         end
         ST_HIST_WR: begin
            if (out_free) begin
               ram_we   = 1'b1;
               ram_wd   = (ram_rd != COUNT_MAX) ? ram_rd + 1'b1 : ram_rd;
               load_out = 1'b1;
               out_kind = RESULT_DISTANCE;
               out_dist = DIST_BITS'(bin_ff);
            end
         end
         ST_READ_DONE: begin
            if (out_free) begin
               load_out  = 1'b1;
               out_kind  = RESULT_COUNT;
               out_count = oor_ff ? '0 : ram_rd;
            end
         end
         default: begin
         end
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      iter_ff <= iter_in;
      bin_ff  <= bin_in;
      oor_ff  <= oor_in;
      if (load_out) begin
         rsp_kind_ff  <= out_kind;
         rsp_dist_ff  <= out_dist;
         rsp_count_ff <= out_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_bin_count   = rsp_count_ff;

endmodule

### hdl/euclidean_distance_histogram_unit.sv
// ----------------------------------------------------------------------------
// euclidean_distance_histogram_unit
// Coordinate samples are taken one per cycle while the queue and the front
// pipe together hold fewer than four jobs and no clearing pass runs; the
// front reads the reference entry and adds one squared difference per
// sample. Each completed vector then occupies the back for an iterative
// square root at one result bit per cycle, then a read-modify-write of
// the histogram RAM. A clear command and the pass after reset write the
// histogram RAM one bin per cycle, with req_stall high meanwhile. The
// back is the limit for short vectors: they fill the four-entry queue
// and then stall the input.
// ----------------------------------------------------------------------------
module euclidean_distance_histogram_unit import edh_pkg::*; #(
   parameter int MAX_DIM   = 128,
   parameter int HIST_BINS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_BITS-1:0]   req_command,
   input  logic [COORD_BITS-1:0] req_coordinate,
   input  logic [INDEX_BITS-1:0] req_bin_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_result_kind,
   output logic [DIST_BITS-1:0]  rsp_distance,
   output logic [COUNT_BITS-1:0] rsp_bin_count,
   input  logic                  csr_write_enable,
   input  logic [DIM_BITS-1:0]   csr_write_data
);

   localparam int ACC_BITS = 2 * COORD_BITS + $clog2(MAX_DIM);
   localparam int Q_WIDTH  = $bits(job_type) + ACC_BITS;

   logic                      push_valid;
   job_type                   push_job;
   logic [ACC_BITS-1:0]       push_acc;
   logic                      pop;
   logic [Q_WIDTH-1:0]        head_data;
   job_type                   head_job;
   logic [ACC_BITS-1:0]       head_acc;
   logic                      queue_empty;
   logic [QUEUE_CNT_BITS-1:0] queue_count;
   logic                      back_clearing;

   edh_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_coordinate   (req_coordinate),
      .req_bin_index    (req_bin_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_count      (queue_count),
      .back_clearing    (back_clearing),
      .push_valid       (push_valid),
      .push_job         (push_job),
      .push_acc         (push_acc)
   );

   edh_queue #(
      .WIDTH (Q_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_job, push_acc}),
      .pop       (pop),
      .head_data (head_data),
      .empty     (queue_empty),
      .count     (queue_count)
   );

   assign head_job = job_type'(head_data[Q_WIDTH-1:ACC_BITS]);
   assign head_acc = head_data[ACC_BITS-1:0];

   edh_back #(
      .MAX_DIM   (MAX_DIM),
      .HIST_BINS (HIST_BINS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .head_job        (head_job),
      .head_acc        (head_acc),
      .pop             (pop),
      .clearing        (back_clearing),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_distance    (rsp_distance),
      .rsp_bin_count   (rsp_bin_count)
   );

endmodule

### hdl/edh_checker.sv
// ----------------------------------------------------------------------------
// edh_checker
// Port-level checks of the distance histogram unit, bound to the top level.
// ----------------------------------------------------------------------------
module edh_checker import edh_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_result_kind,
   input logic [DIST_BITS-1:0]  rsp_distance,
   input logic [COUNT_BITS-1:0] rsp_bin_count
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind) &&
         $stable(rsp_distance) && $stable(rsp_bin_count))
      else $error("stalled result changed");

   a_count_no_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == RESULT_COUNT) |-> rsp_distance == '0)
      else $error("count result carries a distance");

   a_dist_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == RESULT_DISTANCE) |-> rsp_bin_count == '0)
      else $error("distance result carries a count");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // histogram clearing pass starts right out of reset
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input taken during clearing pass");

endmodule

bind euclidean_distance_histogram_unit edh_checker u_edh_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the distance histogram unit. A table of directed
// transactions runs first. Random coordinate streams, bin reads and clears
// follow, in phases at several vector dimensions. Every accepted result is
// compared against the table's expected value or a behavioral model of the histogram.
// ----------------------------------------------------------------------------
module tb;
   import edh_pkg::*;

   localparam int NUM_BINS   = 4096;
   localparam int REF_DEPTH  = 128;
   localparam int IDLE_LIMIT = 100000;
   // up to five clears can sit in the queue, pipe and back at once
   localparam int DRAIN_WAIT = 6 * NUM_BINS;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic                  kind;
      logic [DIST_BITS-1:0]  dist_val;
      logic [COUNT_BITS-1:0] count;
   } result_t;

   typedef struct {
      logic [CMD_BITS-1:0]   cmd;
      logic [COORD_BITS-1:0] coord;
      logic [INDEX_BITS-1:0] index;
      bit                    typed;
      result_t               res;
   } dir_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CMD_BITS-1:0]   req_command = CMD_SAMPLE;
   logic [COORD_BITS-1:0] req_coordinate = '0;
   logic [INDEX_BITS-1:0] req_bin_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_result_kind;
   logic [DIST_BITS-1:0]  rsp_distance;
   logic [COUNT_BITS-1:0] rsp_bin_count;
   logic                  csr_write_enable = 1'b0;
   logic [DIM_BITS-1:0]   csr_write_data = '0;

   // histogram model state
   logic [COORD_BITS-1:0] ref_coords [REF_DEPTH];
   int unsigned           bin_counts [NUM_BINS];
   int unsigned           coord_pos;
   bit                    ref_ready;
   int unsigned           sq_sum;
   logic [DIM_BITS-1:0]   dim_reg;

   result_t               pending_results [$];
   logic [DIST_BITS-1:0]  seen_dists [$];
   bit                    idle_on = 1'b1;
   int                    errors = 0;
   int                    n_items = 0;
   int                    n_dists = 0;
   int                    n_reads = 0;
   int                    n_clears = 0;
   int                    quiet_cycles = 0;

   euclidean_distance_histogram_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_coordinate   (req_coordinate),
      .req_bin_index    (req_bin_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_distance     (rsp_distance),
      .rsp_bin_count    (rsp_bin_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic int unsigned isqrt(int unsigned v);
      int unsigned r;
      int unsigned t;
      r = 0;
      for (int b = 11; b >= 0; b--) begin
         t = r | (32'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic void clear_histogram();
      foreach (bin_counts[i]) bin_counts[i] = 0;
      coord_pos = 0;
      ref_ready = 1'b0;
      sq_sum    = 0;
   endfunction

   // advance the model by one transaction; returns 1 when a result is due
   function automatic bit histogram_step(logic [CMD_BITS-1:0] cmd,
                                         logic [COORD_BITS-1:0] coord,
                                         logic [INDEX_BITS-1:0] index,
                                         output result_t res);
      int unsigned dim;
      int unsigned pos;
      int unsigned diff;
      int unsigned d;
      bit          last;
      res = '{1'b0, '0, '0};
      case (cmd)
         CMD_SAMPLE: begin
            dim = (dim_reg == 0) ? 1 : ((dim_reg > REF_DEPTH) ? REF_DEPTH : dim_reg);
            pos = (coord_pos >= REF_DEPTH) ? REF_DEPTH - 1 : coord_pos;
            last = (pos + 1 >= dim);
            if (!ref_ready) begin
               ref_coords[pos] = coord;
               coord_pos = last ? 0 : pos + 1;
               if (last) ref_ready = 1'b1;
               return 1'b0;
            end
            diff = (coord >= ref_coords[pos]) ? coord - ref_coords[pos]
                                              : ref_coords[pos] - coord;
            sq_sum += diff * diff;
            if (!last) begin
               coord_pos = pos + 1;
               return 1'b0;
            end
            d = isqrt(sq_sum);
            if (d > NUM_BINS - 1) d = NUM_BINS - 1;
            if (bin_counts[d] < COUNT_MAX) bin_counts[d]++;
            sq_sum       = 0;
            coord_pos    = 0;
            res.kind     = RESULT_DISTANCE;
            res.dist_val = DIST_BITS'(d);
            return 1'b1;
         end
         CMD_READ: begin
            res.kind  = RESULT_COUNT;
            res.count = (index < NUM_BINS) ? COUNT_BITS'(bin_counts[index]) : '0;
            return 1'b1;
         end
         CMD_CLEAR: begin
            clear_histogram();
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // drives one transaction and predicts its outcome once it is accepted
   task automatic send(logic [CMD_BITS-1:0] cmd, logic [COORD_BITS-1:0] coord,
                       logic [INDEX_BITS-1:0] index, bit typed = 1'b0,
                       result_t typed_res = '{1'b0, '0, '0});
      result_t res;
      result_t exp_res;
      bit      has;
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_coordinate <= coord;
      req_bin_index  <= index;
      do @(posedge clock); while (req_stall);
      has = histogram_step(cmd, coord, index, res);
      if (has) begin
         exp_res = typed ? typed_res : res;
         pending_results = {pending_results, exp_res};
         if (res.kind == RESULT_DISTANCE) begin
            n_dists++;
            seen_dists = {seen_dists, res.dist_val};
         end else begin
            n_reads++;
         end
      end
      if (cmd == CMD_CLEAR) n_clears++;
      n_items++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // a clear may still be at work in the back end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_dimension(logic [DIM_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      dim_reg = value;
   endtask

   task automatic random_item();
      int                    sel;
      logic [INDEX_BITS-1:0] index;
      sel = $urandom_range(99);
      if (sel < 78) begin
         send(CMD_SAMPLE, COORD_BITS'($urandom_range(255)), INDEX_BITS'($urandom));
      end else if (sel < 94) begin
         if (seen_dists.size() != 0 && $urandom_range(99) < 65)
            index = seen_dists[$urandom_range(seen_dists.size() - 1)];
         else
            index = INDEX_BITS'($urandom_range(NUM_BINS - 1));
         send(CMD_READ, COORD_BITS'($urandom), index);
      end else if (sel < 97) begin
         send(CMD_CLEAR, COORD_BITS'($urandom), INDEX_BITS'($urandom));
      end else begin
         send(CMD_UNUSED, COORD_BITS'($urandom), INDEX_BITS'($urandom));
      end
   endtask

   always @(negedge clock)
      rsp_stall <= idle_on && ($urandom_range(99) < 22);

   always @(posedge clock) begin
      result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result kind=%0d distance=%0d count=%0d", $time,
                     rsp_result_kind, rsp_distance, rsp_bin_count);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.kind) begin
               $display("%0t: result_kind expected %0d actual %0d", $time, want.kind,
                        rsp_result_kind);
               errors++;
            end
            if (rsp_distance !== want.dist_val) begin
               $display("%0t: distance expected %0d actual %0d", $time, want.dist_val,
                        rsp_distance);
               errors++;
            end
            if (rsp_bin_count !== want.count) begin
               $display("%0t: bin_count expected %0d actual %0d", $time, want.count,
                        rsp_bin_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      dir_row_t              rows [$];
      logic [DIM_BITS-1:0]   phase_dims [$];
      int                    phase_len;
      foreach (ref_coords[i]) ref_coords[i] = '0;
      clear_histogram();
      dim_reg = 1;

      // dimension one after reset: each sample after the reference is a vector
      rows = '{
         '{CMD_READ,   8'd0,   12'd0,    1'b1, '{RESULT_COUNT,    12'd0,   20'd0}},
         '{CMD_READ,   8'd0,   12'd4095, 1'b1, '{RESULT_COUNT,    12'd0,   20'd0}},
         '{CMD_SAMPLE, 8'd0,   12'd0,    1'b0, '{1'b0, '0, '0}},
         '{CMD_SAMPLE, 8'd255, 12'd0,    1'b1, '{RESULT_DISTANCE, 12'd255, 20'd0}},
         '{CMD_SAMPLE, 8'd0,   12'd0,    1'b1, '{RESULT_DISTANCE, 12'd0,   20'd0}},
         '{CMD_SAMPLE, 8'd128, 12'd0,    1'b1, '{RESULT_DISTANCE, 12'd128, 20'd0}},
         '{CMD_SAMPLE, 8'd255, 12'd0,    1'b1, '{RESULT_DISTANCE, 12'd255, 20'd0}},
         '{CMD_READ,   8'd0,   12'd255,  1'b1, '{RESULT_COUNT,    12'd0,   20'd2}},
         '{CMD_READ,   8'd0,   12'd0,    1'b1, '{RESULT_COUNT,    12'd0,   20'd1}},
         '{CMD_READ,   8'd255, 12'd4095, 1'b1, '{RESULT_COUNT,    12'd0,   20'd0}},
         '{CMD_UNUSED, 8'd255, 12'd4095, 1'b0, '{1'b0, '0, '0}},
         '{CMD_SAMPLE, 8'd170, 12'd0,    1'b0, '{1'b0, '0, '0}},
         '{CMD_SAMPLE, 8'd85,  12'd2730, 1'b0, '{1'b0, '0, '0}},
         '{CMD_READ,   8'd0,   12'd1365, 1'b0, '{1'b0, '0, '0}},
         '{CMD_CLEAR,  8'd0,   12'd0,    1'b0, '{1'b0, '0, '0}},
         '{CMD_READ,   8'd0,   12'd255,  1'b1, '{RESULT_COUNT,    12'd0,   20'd0}},
         '{CMD_SAMPLE, 8'd255, 12'd0,    1'b0, '{1'b0, '0, '0}},
         '{CMD_SAMPLE, 8'd0,   12'd0,    1'b1, '{RESULT_DISTANCE, 12'd255, 20'd0}},
         '{CMD_READ,   8'd0,   12'd255,  1'b1, '{RESULT_COUNT,    12'd0,   20'd1}},
         '{CMD_READ,   8'd0,   12'd0,    1'b1, '{RESULT_COUNT,    12'd0,   20'd0}}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send(rows[i].cmd, rows[i].coord, rows[i].index, rows[i].typed, rows[i].res);
      drain();

      // dimension zero acts as one, above the maximum it saturates
      phase_dims = '{8'd3, 8'd0, 8'd128, 8'd2, 8'd255, 8'd200, 8'd5, 8'd1, 8'd16};
      foreach (phase_dims[p]) begin
         write_dimension(phase_dims[p]);
         send(CMD_CLEAR, COORD_BITS'($urandom), INDEX_BITS'($urandom));
         phase_len = (phase_dims[p] >= 128) ? 180 : 110;
         if (p == 3) idle_on = 1'b0;
         for (int k = 0; k < phase_len; k++) random_item();
         idle_on = 1'b1;
         drain();
      end

      // lower the dimension in mid vector without a clear
      repeat (7) send(CMD_SAMPLE, COORD_BITS'($urandom_range(255)), INDEX_BITS'($urandom));
      drain();
      write_dimension(8'd5);
      for (int k = 0; k < 100; k++) random_item();
      drain();

      $display("%0d transactions sent: %0d distances, %0d bin reads, %0d clears",
               n_items, n_dists, n_reads, n_clears);
      $display("dimensions covered: 0, 1, 2, 3, 5, 16, 128, 200, 255 and a mid-vector change");
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
